FILE: rtl/sui_pkg.sv
// shared types, codes and microcode for the two-set union/intersection unit
// no dependencies; used by sui_store and two_set_union_intersection
package sui_pkg;

    localparam int SET_CAPACITY_DEF = 8;
    localparam int DATA_W = 32;
    localparam int PC_W = 4;

    typedef logic signed [DATA_W-1:0] data_t;

    // input commands
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_LOAD  = 3'd0;
    localparam logic [2:0] KIND_INTER = 3'd1;
    localparam logic [2:0] KIND_UNION = 3'd2;
    localparam logic [2:0] KIND_AMB   = 3'd3;
    localparam logic [2:0] KIND_BMA   = 3'd4;

    // load status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // program addresses
    localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
    localparam logic [PC_W-1:0] PC_LOAD    = 4'd1;
    localparam logic [PC_W-1:0] PC_COMP    = 4'd2;
    localparam logic [PC_W-1:0] PC_INTER_C = 4'd3;
    localparam logic [PC_W-1:0] PC_UNION_A = 4'd4;
    localparam logic [PC_W-1:0] PC_UNION_B = 4'd5;
    localparam logic [PC_W-1:0] PC_UNION_C = 4'd6;
    localparam logic [PC_W-1:0] PC_AMB     = 4'd7;
    localparam logic [PC_W-1:0] PC_AMB_C   = 4'd8;
    localparam logic [PC_W-1:0] PC_BMA     = 4'd9;
    localparam logic [PC_W-1:0] PC_BMA_C   = 4'd10;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_LSCAN,
        OP_FILT,
        OP_CLOSE
    } op_t;

    typedef enum logic [1:0] {
        OTH_A,
        OTH_B,
        OTH_NONE
    } oth_t;

    typedef struct packed {
        op_t             op;
        logic [2:0]      kind;
        logic            src_b;
        oth_t            oth;
        logic            want_in;
        logic            fin;
        logic [PC_W-1:0] next;
    } uword_t;

    typedef struct packed {
        logic wr_en;
        logic wr_sel_b;
        logic clr;
    } sto_ctrl_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        begin
            w = '0;
            w.oth = OTH_NONE;
            unique case (pc)
                PC_WAIT: begin
                    w.op = OP_WAIT;
                    w.next = PC_COMP;
                end
                PC_LOAD: begin
                    w.op = OP_LSCAN;
                    w.next = PC_WAIT;
                end
                PC_COMP: begin
                    w.op = OP_FILT; w.kind = KIND_INTER; w.src_b = 1'b0;
                    w.oth = OTH_B; w.want_in = 1'b1; w.next = PC_INTER_C;
                end
                PC_INTER_C: begin
                    w.op = OP_CLOSE; w.kind = KIND_INTER; w.next = PC_UNION_A;
                end
                PC_UNION_A: begin
                    w.op = OP_FILT; w.kind = KIND_UNION; w.src_b = 1'b0;
                    w.oth = OTH_NONE; w.want_in = 1'b0; w.next = PC_UNION_B;
                end
                PC_UNION_B: begin
                    w.op = OP_FILT; w.kind = KIND_UNION; w.src_b = 1'b1;
                    w.oth = OTH_A; w.want_in = 1'b0; w.next = PC_UNION_C;
                end
                PC_UNION_C: begin
                    w.op = OP_CLOSE; w.kind = KIND_UNION; w.next = PC_AMB;
                end
                PC_AMB: begin
                    w.op = OP_FILT; w.kind = KIND_AMB; w.src_b = 1'b0;
                    w.oth = OTH_B; w.want_in = 1'b0; w.next = PC_AMB_C;
                end
                PC_AMB_C: begin
                    w.op = OP_CLOSE; w.kind = KIND_AMB; w.next = PC_BMA;
                end
                PC_BMA: begin
                    w.op = OP_FILT; w.kind = KIND_BMA; w.src_b = 1'b1;
                    w.oth = OTH_A; w.want_in = 1'b0; w.next = PC_BMA_C;
                end
                PC_BMA_C: begin
                    w.op = OP_CLOSE; w.kind = KIND_BMA; w.fin = 1'b1;
                    w.next = PC_WAIT;
                end
                default: begin
                    w.op = OP_WAIT;
                    w.next = PC_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/sui_store.sv
// element stores and fill counts for sets A and B
// depends on sui_pkg; one read port per set, append-at-count write
module sui_store #(
    parameter int CAP = sui_pkg::SET_CAPACITY_DEF,
    parameter int IDX_W = (CAP > 1) ? $clog2(CAP) : 1,
    parameter int CNT_W = $clog2(CAP + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sui_pkg::sto_ctrl_t   ctrl,
    input  sui_pkg::data_t       wr_data,
    input  logic [IDX_W-1:0]     addr_a,
    input  logic [IDX_W-1:0]     addr_b,
    output sui_pkg::data_t       rd_a,
    output sui_pkg::data_t       rd_b,
    output logic [CNT_W-1:0]     cnt_a,
    output logic [CNT_W-1:0]     cnt_b
);

    sui_pkg::data_t   mem_a [CAP];
    sui_pkg::data_t   mem_b [CAP];
    logic [CNT_W-1:0] cnt_a_reg;
    logic [CNT_W-1:0] cnt_b_reg;
    logic [CNT_W-1:0] cnt_a_next;
    logic [CNT_W-1:0] cnt_b_next;

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        if (ctrl.clr)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end
        else if (ctrl.wr_en && !ctrl.wr_sel_b)
        begin
            cnt_a_next = cnt_a_reg + 1'b1;
        end
        else if (ctrl.wr_en && ctrl.wr_sel_b)
        begin
            cnt_b_next = cnt_b_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    // appends go to the slot at the current count
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && !ctrl.clr && !ctrl.wr_sel_b)
        begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= wr_data;
        end
        if (ctrl.wr_en && !ctrl.clr && ctrl.wr_sel_b)
        begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    assign rd_a  = mem_a[addr_a];
    assign rd_b  = mem_b[addr_b];
    assign cnt_a = cnt_a_reg;
    assign cnt_b = cnt_b_reg;

endmodule

FILE: rtl/two_set_union_intersection.sv
// top level of the two-set union/intersection unit: microcoded sequencer
// depends on sui_pkg (microcode, codes, types) and sui_store (set storage)
//
// Loads into set A or B check the target set for a duplicate before their
// result is given: the duplicate check compares one stored element per cycle.
// A compute transaction runs five filter passes and four list closes from a
// microcode table; each element of the scanned set is compared against the
// elements of the other set, and a compute also waits while the result side
// stalls. One list element is held back so that the final element of each
// list carries list_last. Commands are taken one at a time; the next
// transaction is accepted while the last result still waits in the output
// register.
module two_set_union_intersection #(
    parameter int SET_CAPACITY = sui_pkg::SET_CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           cmd,
    input  logic signed [31:0]   value,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [2:0]           kind,
    output logic [1:0]           status,
    output logic                 present,
    output logic signed [31:0]   value_res,
    output logic                 list_last,
    output logic                 last
);

    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);

    sui_pkg::uword_t    uw;
    sui_pkg::sto_ctrl_t sto;

    logic [sui_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     tgt_b_reg, tgt_b_next;
    sui_pkg::data_t           val_reg, val_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [2:0]               pend_kind_reg, pend_kind_next;
    sui_pkg::data_t           pend_val_reg, pend_val_next;
    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               out_kind_reg, out_kind_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic                     out_present_reg, out_present_next;
    sui_pkg::data_t           out_val_reg, out_val_next;
    logic                     out_ll_reg, out_ll_next;
    logic                     out_last_reg, out_last_next;

    logic             src_b;
    logic [IDX_W-1:0] addr_a, addr_b;
    sui_pkg::data_t   rd_a, rd_b;
    logic [CNT_W-1:0] cnt_a, cnt_b;
    sui_pkg::data_t   src_val, oth_val, tgt_val;
    logic [CNT_W-1:0] scnt, ocnt, tcnt;
    logic             out_free;
    logic             hit;
    logic             close_fire;

    sui_store #(
        .CAP   (SET_CAPACITY),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sto),
        .wr_data (val_reg),
        .addr_a  (addr_a),
        .addr_b  (addr_b),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .cnt_a   (cnt_a),
        .cnt_b   (cnt_b)
    );

    // datapath selection driven by the current control word
    always_comb
    begin
        uw     = sui_pkg::ucode(pc_reg);
        src_b  = (uw.op == sui_pkg::OP_LSCAN) ? tgt_b_reg : uw.src_b;
        addr_a = (uw.op == sui_pkg::OP_FILT && !src_b) ? i_reg[IDX_W-1:0]
                                                       : j_reg[IDX_W-1:0];
        addr_b = (uw.op == sui_pkg::OP_FILT && src_b) ? i_reg[IDX_W-1:0]
                                                      : j_reg[IDX_W-1:0];
        src_val = src_b ? rd_b : rd_a;
        oth_val = src_b ? rd_a : rd_b;
        tgt_val = tgt_b_reg ? rd_b : rd_a;
        scnt    = src_b ? cnt_b : cnt_a;
        tcnt    = tgt_b_reg ? cnt_b : cnt_a;
        case (uw.oth)
            sui_pkg::OTH_A: ocnt = cnt_a;
            sui_pkg::OTH_B: ocnt = cnt_b;
            default:        ocnt = '0;
        endcase
        hit      = (j_reg < ocnt);
        out_free = !out_valid_reg || res_ready;
    end

    always_comb
    begin
        pc_next          = pc_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        tgt_b_next       = tgt_b_reg;
        val_next         = val_reg;
        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_val_next    = pend_val_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_present_next = out_present_reg;
        out_val_next     = out_val_reg;
        out_ll_next      = out_ll_reg;
        out_last_next    = out_last_reg;
        sto              = '0;
        item_ready       = (uw.op == sui_pkg::OP_WAIT);
        close_fire       = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (uw.op)
            sui_pkg::OP_WAIT:
            begin
                if (item_valid)
                begin
                    i_next = '0;
                    j_next = '0;
                    case (cmd)
                        sui_pkg::CMD_LOAD_A, sui_pkg::CMD_LOAD_B:
                        begin
                            tgt_b_next = (cmd == sui_pkg::CMD_LOAD_B);
                            val_next   = value;
                            pc_next    = sui_pkg::PC_LOAD;
                        end
                        sui_pkg::CMD_COMPUTE:
                        begin
                            pc_next = uw.next;
                        end
                        default:
                        begin
                            pc_next = pc_reg;
                        end
                    endcase
                end
            end
            sui_pkg::OP_LSCAN:
            begin
                if (j_reg < tcnt && tgt_val != val_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else if (out_free)
                begin
                    // duplicate check wins over the full check
                    if (j_reg < tcnt)
                    begin
                        out_status_next = sui_pkg::ST_DUP;
                    end
                    else if (tcnt >= CAP_CNT)
                    begin
                        out_status_next = sui_pkg::ST_FULL;
                    end
                    else
                    begin
                        out_status_next = sui_pkg::ST_OK;
                        sto.wr_en       = 1'b1;
                        sto.wr_sel_b    = tgt_b_reg;
                    end
                    out_valid_next   = 1'b1;
                    out_kind_next    = sui_pkg::KIND_LOAD;
                    out_present_next = 1'b0;
                    out_val_next     = '0;
                    out_ll_next      = 1'b1;
                    out_last_next    = 1'b1;
                    pc_next          = uw.next;
                end
            end
            sui_pkg::OP_FILT:
            begin
                if (i_reg >= scnt)
                begin
                    pc_next = uw.next;
                    i_next  = '0;
                    j_next  = '0;
                end
                else if (hit && src_val != oth_val)
                begin
                    j_next = j_reg + 1'b1;
                end
                else if (hit != uw.want_in)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = '0;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // push the held element out, hold the new one
                    if (pend_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_kind_next    = pend_kind_reg;
                        out_status_next  = sui_pkg::ST_OK;
                        out_present_next = 1'b1;
                        out_val_next     = pend_val_reg;
                        out_ll_next      = 1'b0;
                        out_last_next    = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_kind_next  = uw.kind;
                    pend_val_next   = src_val;
                    i_next          = i_reg + 1'b1;
                    j_next          = '0;
                end
            end
            sui_pkg::OP_CLOSE:
            begin
                if (out_free)
                begin
                    close_fire       = 1'b1;
                    out_valid_next   = 1'b1;
                    out_kind_next    = uw.kind;
                    out_status_next  = sui_pkg::ST_OK;
                    out_present_next = pend_valid_reg;
                    out_val_next     = pend_valid_reg ? pend_val_reg : '0;
                    out_ll_next      = 1'b1;
                    out_last_next    = uw.fin;
                    pend_valid_next  = 1'b0;
                    sto.clr          = uw.fin;
                    pc_next          = uw.next;
                end
            end
            default:
            begin
                pc_next = sui_pkg::PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= sui_pkg::PC_WAIT;
            i_reg           <= '0;
            j_reg           <= '0;
            tgt_b_reg       <= 1'b0;
            val_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_kind_reg   <= '0;
            pend_val_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= '0;
            out_status_reg  <= '0;
            out_present_reg <= 1'b0;
            out_val_reg     <= '0;
            out_ll_reg      <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            pc_reg          <= pc_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            tgt_b_reg       <= tgt_b_next;
            val_reg         <= val_next;
            pend_valid_reg  <= pend_valid_next;
            pend_kind_reg   <= pend_kind_next;
            pend_val_reg    <= pend_val_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_status_reg  <= out_status_next;
            out_present_reg <= out_present_next;
            out_val_reg     <= out_val_next;
            out_ll_reg      <= out_ll_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign status    = out_status_reg;
    assign present   = out_present_reg;
    assign value_res = out_val_reg;
    assign list_last = out_ll_reg;
    assign last      = out_last_reg;

    // no element may be held back while waiting for a command
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == sui_pkg::OP_WAIT) |-> !pend_valid_reg)
        else $error("held element left over after compute");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a <= CAP_CNT) && (cnt_b <= CAP_CNT))
        else $error("set count beyond capacity");

    a_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == sui_pkg::KIND_LOAD)
            |-> (out_ll_reg && out_last_reg && !out_present_reg))
        else $error("load status result with wrong flags");

    a_clear_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (close_fire && uw.fin) |=> (cnt_a == '0 && cnt_b == '0))
        else $error("sets not cleared after compute");

    a_last_has_ll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_ll_reg)
        else $error("final result of a transaction not closing its list");

endmodule
